>>> sv/qlcm_pkg.sv
`default_nettype none
package qlcm_pkg;

    localparam int PIX_W      = 8;
    localparam int VAL_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int OCOL_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_FIELD_W = VAL_W + OCOL_W + HEIGHT_W;

    typedef logic [PIX_W-1:0] t_level;

    localparam logic [CFG_IDX_W-1:0] CFG_EQUIDIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTOUR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd4;

    localparam logic [PIX_W-1:0]    EQUI_RESET    = 8'd20;
    localparam logic [PIX_W-1:0]    EQUI_MIN      = 8'd2;
    localparam logic [VAL_W-1:0]    CONTOUR_RESET = 8'd0;
    localparam logic [VAL_W-1:0]    BACKGND_RESET = 8'd255;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET   = 11'd512;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = 16'd512;

endpackage
`default_nettype wire

>>> sv/qlcm_div.sv
`default_nettype none
module qlcm_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [qlcm_pkg::PIX_W-1:0] i_dividend,
    input  wire logic [qlcm_pkg::PIX_W-1:0] i_divisor,
    output logic                          o_done,
    output qlcm_pkg::t_level              o_quotient
);

    localparam int W  = qlcm_pkg::PIX_W;
    localparam int CNTW = $clog2(W);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_rem;
    logic            r_done;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] n_rem;

    // one restoring step per cycle, msb first
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = !diff[W];
        n_rem = ge ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

>>> sv/qlcm_line_buf.sv
`default_nettype none
module qlcm_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire qlcm_pkg::t_level  i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr0,
    input  wire logic [AW-1:0]     i_raddr1,
    output qlcm_pkg::t_level       o_rdata0,
    output qlcm_pkg::t_level       o_rdata1
);

    qlcm_pkg::t_level mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= mem[i_raddr0];
            o_rdata1 <= mem[i_raddr1];
        end
    end

endmodule
`default_nettype wire

>>> sv/quantized_level_contour_map.sv
// quantized_level_contour_map
// pixels of a frame enter in raster order on the s_axis channel (tdata = pixel).
// each pixel is quantized to a level (pixel / equidistance) and compared with
// its right and lower neighbours; results leave on the m_axis channel with
// tdata = {pad, out_row, out_column, out_value} and tlast on the final result
// of an input transfer. every row but row 0 gives the result of the pixel above,
// and the last row also flushes itself, so one input transfer yields zero to
// three results.
// flow: a new input transfer is taken only in the idle state, after the
// bit-serial divider has produced the level, the line buffer has been read and
// written back, and every result of the item has entered the output register.
// configuration: i_cfg_we / i_cfg_index / i_cfg_wdata, written while idle;
// a width or height write restarts the frame at row 0, column 0.
// reset: registers return to their defaults, counters to zero, no result is
// pending; the line buffer is not cleared (row 0 writes it before any read value is used).
// stall: a result waits in the output register while i_m_axis_tready is low,
// and no new input transfer is taken until the last result of the item has
// entered the output register.
`default_nettype none
module quantized_level_contour_map #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // pixel[7:0]
    input  wire logic [qlcm_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // out_value[7:0], out_column[17:8], out_row[33:18], zero[39:34]
    output logic [qlcm_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output logic                                     o_m_axis_tlast,
    input  wire logic                                i_cfg_we,
    input  wire logic [qlcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [qlcm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = qlcm_pkg::WIDTH_W;
    localparam int HW   = qlcm_pkg::HEIGHT_W;
    localparam int VW   = qlcm_pkg::VAL_W;
    localparam int OCW  = qlcm_pkg::OCOL_W;
    localparam int CMPW = (CW + 1 > WW) ? CW + 1 : WW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;

    logic [qlcm_pkg::PIX_W-1:0] r_equi;
    logic [VW-1:0]              r_cval;
    logic [VW-1:0]              r_bval;
    logic [WW-1:0]              r_width;
    logic [HW-1:0]              r_height;

    logic [CW-1:0]    r_col;
    logic [HW-1:0]    r_row;
    logic [CW-1:0]    r_cur_col;
    logic [HW-1:0]    r_cur_row;
    logic             r_cur_last_col;
    qlcm_pkg::t_level r_prev_level;

    logic [2:0] r_pend;
    logic       r_diff0;
    logic       r_diff1;

    logic                     r_ovalid;
    logic [VW-1:0]            r_oval;
    logic [OCW-1:0]           r_ocol;
    logic [HW-1:0]            r_orow;
    logic                     r_olast;

    logic             in_xfer;
    logic             last_col;
    logic             last_row;
    logic             div_done;
    qlcm_pkg::t_level lvl;
    qlcm_pkg::t_level up0;
    qlcm_pkg::t_level up1;
    logic             diff0;
    logic             diff1;
    logic             cur_last_row;
    logic [2:0]       new_pend;
    logic [2:0]       n_pend;
    logic             load;
    logic [2:0]       sel;
    logic [VW-1:0]    sel_val;
    logic [CW-1:0]    sel_col;
    logic [HW-1:0]    sel_row;
    logic [CMPW-1:0]  wr_width;
    logic [HW-1:0]    wr_height;
    logic             mem_we;

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign last_col = (CMPW'(r_col) + 1'b1) >= CMPW'(r_width);
    assign last_row = ({1'b0, r_row} + 1'b1) >= {1'b0, r_height};
    assign mem_we   = (r_state == S_DIV) && div_done;

    qlcm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_dividend (i_s_axis_tdata[qlcm_pkg::PIX_W-1:0]),
        .i_divisor  (r_equi),
        .o_done     (div_done),
        .o_quotient (lvl)
    );

    qlcm_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (r_cur_col),
        .i_wdata  (lvl),
        .i_re     (in_xfer),
        .i_raddr0 (r_col),
        .i_raddr1 (r_col + 1'b1),
        .o_rdata0 (up0),
        .o_rdata1 (up1)
    );

    always_comb begin
        diff0 = (up0 != lvl) || (!r_cur_last_col && (up0 != up1));
        diff1 = r_prev_level != lvl;
    end

    // results owed by the pixel whose level is ready
    always_comb begin
        cur_last_row = ({1'b0, r_cur_row} + 1'b1) >= {1'b0, r_height};
        new_pend     = {r_cur_last_col && cur_last_row,
                        cur_last_row && (r_cur_col != '0),
                        r_cur_row != '0};
    end

    // pick the oldest pending result
    always_comb begin
        if (r_pend[0]) begin
            sel = 3'b001;
        end else if (r_pend[1]) begin
            sel = 3'b010;
        end else begin
            sel = 3'b100;
        end
        n_pend = r_pend & ~sel;
        case (sel)
            3'b001: begin
                sel_val = r_diff0 ? r_cval : r_bval;
                sel_col = r_cur_col;
                sel_row = r_cur_row - 1'b1;
            end
            3'b010: begin
                sel_val = r_diff1 ? r_cval : r_bval;
                sel_col = r_cur_col - 1'b1;
                sel_row = r_cur_row;
            end
            default: begin
                sel_val = r_bval;
                sel_col = r_cur_col;
                sel_row = r_cur_row;
            end
        endcase
        load    = (r_state == S_EMIT) && (!r_ovalid || i_m_axis_tready);
    end

    always_comb begin
        wr_width = CMPW'(i_cfg_wdata[WW-1:0]);
        if (wr_width == '0) begin
            wr_width = CMPW'(1);
        end else if (wr_width > CMPW'(MAX_WIDTH)) begin
            wr_width = CMPW'(MAX_WIDTH);
        end
        wr_height = i_cfg_wdata[HW-1:0];
        if (wr_height == '0) begin
            wr_height = HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_equi       <= qlcm_pkg::EQUI_RESET;
            r_cval       <= qlcm_pkg::CONTOUR_RESET;
            r_bval       <= qlcm_pkg::BACKGND_RESET;
            r_width      <= qlcm_pkg::WIDTH_RESET;
            r_height     <= qlcm_pkg::HEIGHT_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_prev_level <= '0;
            r_pend       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_DIV;
                        if (last_col) begin
                            r_col <= '0;
                            r_row <= last_row ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_prev_level <= lvl;
                        r_pend       <= new_pend;
                        if (new_pend == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_pend <= n_pend;
                        if (n_pend == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    qlcm_pkg::CFG_EQUIDIST: begin
                        r_equi <= (i_cfg_wdata[qlcm_pkg::PIX_W-1:0] < qlcm_pkg::EQUI_MIN)
                                  ? qlcm_pkg::EQUI_MIN : i_cfg_wdata[qlcm_pkg::PIX_W-1:0];
                    end
                    qlcm_pkg::CFG_CONTOUR: begin
                        r_cval <= i_cfg_wdata[VW-1:0];
                    end
                    qlcm_pkg::CFG_BACKGND: begin
                        r_bval <= i_cfg_wdata[VW-1:0];
                    end
                    qlcm_pkg::CFG_WIDTH: begin
                        r_width <= wr_width[WW-1:0];
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    qlcm_pkg::CFG_HEIGHT: begin
                        r_height <= wr_height;
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cur_col      <= r_col;
            r_cur_row      <= r_row;
            r_cur_last_col <= last_col;
        end
        if (mem_we) begin
            r_diff0 <= diff0;
            r_diff1 <= diff1;
        end
        if (load) begin
            r_oval  <= sel_val;
            r_ocol  <= OCW'(sel_col);
            r_orow  <= sel_row;
            r_olast <= (n_pend == '0);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {{(qlcm_pkg::OUT_TDATA_W - qlcm_pkg::OUT_FIELD_W){1'b0}},
                              r_orow, r_ocol, r_oval};

endmodule
`default_nettype wire

>>> sv/qlcm_checker.sv
`default_nettype none
module qlcm_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    input  wire logic                                o_s_axis_tready,
    input  wire logic                                o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    input  wire logic [qlcm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  wire logic                                o_m_axis_tlast
);

    localparam int PADW = qlcm_pkg::OUT_TDATA_W - qlcm_pkg::OUT_FIELD_W;

    // a result held by the receiver stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output transfer changed while stalled");

    // reset leaves the block ready with nothing to send
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block not idle after reset");

    // the divider is busy right after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while previous pixel in progress");

    // pad bits of tdata stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[qlcm_pkg::OUT_TDATA_W-1 -: PADW] == '0)
        else $error("output pad bits not zero");

endmodule

bind quantized_level_contour_map qlcm_checker u_qlcm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

>>> sim/quantized_level_contour_map_tb.sv
`timescale 1ns / 1ps
module quantized_level_contour_map_tb;

    localparam int PIX_W         = qlcm_pkg::PIX_W;
    localparam int VAL_W         = qlcm_pkg::VAL_W;
    localparam int OCOL_W        = qlcm_pkg::OCOL_W;
    localparam int WIDTH_W       = qlcm_pkg::WIDTH_W;
    localparam int HEIGHT_W      = qlcm_pkg::HEIGHT_W;
    localparam int IN_TDATA_W    = qlcm_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W   = qlcm_pkg::OUT_TDATA_W;
    localparam int CFG_IDX_W     = qlcm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = qlcm_pkg::CFG_DATA_W;
    localparam int LINE_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 30;
    localparam int RANDOM_PIXELS = 95;
    localparam int COL_LSB       = VAL_W;
    localparam int ROW_LSB       = VAL_W + OCOL_W;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [OCOL_W-1:0]   column;
        logic [HEIGHT_W-1:0] row;
        logic                last;
    } t_contour_px;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tready  = 1'b1;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tlast;

    // predictor state and register copies
    int               divisor_r  = int'(qlcm_pkg::EQUI_RESET);
    logic [VAL_W-1:0] contour_r  = qlcm_pkg::CONTOUR_RESET;
    logic [VAL_W-1:0] backgnd_r  = qlcm_pkg::BACKGND_RESET;
    int               cols_r     = int'(qlcm_pkg::WIDTH_RESET);
    int               rows_r     = int'(qlcm_pkg::HEIGHT_RESET);
    qlcm_pkg::t_level level_row [LINE_DEPTH];
    qlcm_pkg::t_level left_level = '0;
    int               col_pos    = 0;
    int               row_pos    = 0;

    t_contour_px      expected_px [$];
    logic [PIX_W-1:0] pixel_seq [$];

    bit stalls_on    = 1'b1;
    int pixels_sent  = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int mismatches   = 0;

    quantized_level_contour_map #(
        .MAX_WIDTH(LINE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int pick_gap();
        int p;
        if (!stalls_on) return 0;
        p = int'($urandom_range(0, 99));
        if (p < 55) return 0;
        if (p < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int base);
        int v;
        if ($urandom_range(0, 99) < 25) return PIX_W'($urandom);
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIX_W-1:0];
    endfunction

    function automatic t_contour_px make_px(input logic is_contour, input int col,
                                            input int row);
        t_contour_px px;
        px.value  = is_contour ? contour_r : backgnd_r;
        px.column = col[OCOL_W-1:0];
        px.row    = row[HEIGHT_W-1:0];
        px.last   = 1'b0;
        return px;
    endfunction

    function automatic void predict_contours(input logic [PIX_W-1:0] pix);
        qlcm_pkg::t_level lvl;
        t_contour_px      px [3];
        int               n;
        logic             at_col_end;
        logic             at_row_end;
        logic             differs;
        lvl = PIX_W'(int'(pix) / divisor_r);
        at_col_end = (col_pos + 1 >= cols_r);
        at_row_end = (row_pos + 1 >= rows_r);
        n = 0;
        if (row_pos >= 1) begin
            differs = (level_row[col_pos] != lvl);
            if (!at_col_end)
                differs = differs || (level_row[col_pos] != level_row[col_pos + 1]);
            px[n] = make_px(differs, col_pos, row_pos - 1);
            n++;
        end
        if (at_row_end) begin
            if (col_pos >= 1) begin
                px[n] = make_px(left_level != lvl, col_pos - 1, row_pos);
                n++;
            end
            // bottom-right corner is always background
            if (at_col_end) begin
                px[n] = make_px(1'b0, col_pos, row_pos);
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            px[k].last = (k == n - 1);
            expected_px.push_back(px[k]);
        end
        level_row[col_pos] = lvl;
        left_level = lvl;
        if (at_col_end) begin
            col_pos = 0;
            row_pos = at_row_end ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s expected %0d got %0d", results_seen, what, want,
                     got);
    endtask

    // output side: check each transfer against the oldest expected pixel
    always @(posedge i_clk) begin : check_results
        t_contour_px want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_px.size() == 0) begin
                report_mismatch("unexpected transfer, tdata", 64'd0, longint'(m_tdata));
            end else begin
                want = expected_px.pop_front();
                if (m_tdata[VAL_W-1:0] !== want.value)
                    report_mismatch("out_value", longint'(want.value),
                                    longint'(m_tdata[VAL_W-1:0]));
                if (m_tdata[COL_LSB +: OCOL_W] !== want.column)
                    report_mismatch("out_column", longint'(want.column),
                                    longint'(m_tdata[COL_LSB +: OCOL_W]));
                if (m_tdata[ROW_LSB +: HEIGHT_W] !== want.row)
                    report_mismatch("out_row", longint'(want.row),
                                    longint'(m_tdata[ROW_LSB +: HEIGHT_W]));
                if (m_tlast !== want.last)
                    report_mismatch("tlast", longint'(want.last), longint'(m_tlast));
            end
        end
    end

    // output side back-pressure
    initial begin : sink_stalls
        int g;
        forever begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            g = pick_gap();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_contours(pix);
        pixels_sent++;
    endtask

    task automatic send_seq();
        foreach (pixel_seq[k]) send_pixel(pixel_seq[k]);
    endtask

    task automatic send_pixels(input int count, input int base);
        for (int k = 0; k < count; k++) send_pixel(pick_pixel(base));
    endtask

    // wait until the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        int v;
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            qlcm_pkg::CFG_EQUIDIST: begin
                v = int'(data[PIX_W-1:0]);
                divisor_r = (v < int'(qlcm_pkg::EQUI_MIN)) ? int'(qlcm_pkg::EQUI_MIN) : v;
            end
            qlcm_pkg::CFG_CONTOUR: begin
                contour_r = data[VAL_W-1:0];
            end
            qlcm_pkg::CFG_BACKGND: begin
                backgnd_r = data[VAL_W-1:0];
            end
            qlcm_pkg::CFG_WIDTH: begin
                v = int'(data[WIDTH_W-1:0]);
                if (v < 1) v = 1;
                if (v > LINE_DEPTH) v = LINE_DEPTH;
                cols_r  = v;
                col_pos = 0;
                row_pos = 0;
            end
            qlcm_pkg::CFG_HEIGHT: begin
                v = int'(data[HEIGHT_W-1:0]);
                rows_r  = (v < 1) ? 1 : v;
                col_pos = 0;
                row_pos = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic test_default_geometry();
        // part of a first row at the reset geometry, then a one-row frame with reset values
        for (int k = 0; k < 8; k++) send_pixel(PIX_W'($urandom));
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd1);
        for (int k = 0; k < 12; k++) send_pixel(PIX_W'($urandom));
    endtask

    task automatic test_field_extremes();
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd3);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd3);
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'd0);
        write_reg(qlcm_pkg::CFG_CONTOUR, 16'hA5C3);
        write_reg(qlcm_pkg::CFG_BACKGND, 16'h1E3C);
        pixel_seq = {8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd254, 8'd128, 8'd127, 8'd255};
        send_seq();
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'd255);
        pixel_seq = {8'd254, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
        send_seq();
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'd1);
        write_reg(qlcm_pkg::CFG_CONTOUR, 16'd255);
        write_reg(qlcm_pkg::CFG_BACKGND, 16'd0);
        pixel_seq = {8'd85, 8'd170, 8'd15, 8'd240, 8'd3, 8'd2, 8'd1, 8'd0, 8'd255};
        send_seq();
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'h0107);
        send_pixels(9, 40);
    endtask

    task automatic test_tiny_frames();
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd0);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd0);
        send_pixels(3, 100);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd3);
        send_pixels(3, 100);
        write_reg(qlcm_pkg::CFG_WIDTH, 16'h0800);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd2);
        send_pixels(4, 100);
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd2);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd1);
        send_pixels(4, 100);
    endtask

    task automatic test_unused_index();
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd4);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd2);
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'd16);
        write_reg(qlcm_pkg::CFG_CONTOUR, 16'd7);
        write_reg(qlcm_pkg::CFG_BACKGND, 16'd200);
        for (int k = int'(qlcm_pkg::CFG_HEIGHT) + 1; k < 2 ** CFG_IDX_W; k++) begin
            write_reg(k[CFG_IDX_W-1:0], 16'hFFFF);
            write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
        end
        send_pixels(8, 64);
    endtask

    task automatic test_midframe_divisor();
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd4);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd3);
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'd10);
        send_pixels(6, 50);
        // stored levels keep the old divisor
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'd3);
        send_pixels(6, 50);
    endtask

    task automatic test_geometry_restart();
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd5);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd4);
        send_pixels(7, 120);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd3);
        send_pixels(15, 120);
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd6);
        send_pixels(8, 120);
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd3);
        send_pixels(9, 120);
    endtask

    task automatic test_tall_frame();
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'hFF00);
        write_reg(qlcm_pkg::CFG_WIDTH, 16'd2);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'hFFFF);
        send_pixels(12, 10);
    endtask

    task automatic test_max_width();
        stalls_on = 1'b0;
        write_reg(qlcm_pkg::CFG_EQUIDIST, 16'd2);
        write_reg(qlcm_pkg::CFG_WIDTH, 16'hFFFF);
        write_reg(qlcm_pkg::CFG_HEIGHT, 16'd1);
        send_pixels(24, int'($urandom_range(0, 255)));
        stalls_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int sent;
        int p;
        int w;
        int h;
        int n;
        int divisor;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            p = int'($urandom_range(0, 9));
            if (p == 0) divisor = int'($urandom_range(0, 1));
            else if (p == 1) divisor = 255;
            else if (p == 2) divisor = 2;
            else divisor = int'($urandom_range(3, 64));
            p = int'($urandom_range(0, 19));
            if (p < 15) w = int'($urandom_range(1, 8));
            else if (p < 19) w = int'($urandom_range(9, 40));
            else w = int'($urandom_range(41, 120));
            h = (w > 40) ? int'($urandom_range(1, 2)) : int'($urandom_range(1, 6));
            write_reg(qlcm_pkg::CFG_EQUIDIST, {8'($urandom), divisor[7:0]});
            write_reg(qlcm_pkg::CFG_CONTOUR, CFG_DATA_W'($urandom));
            write_reg(qlcm_pkg::CFG_BACKGND, CFG_DATA_W'($urandom));
            write_reg(qlcm_pkg::CFG_WIDTH, {5'($urandom), w[WIDTH_W-1:0]});
            write_reg(qlcm_pkg::CFG_HEIGHT, h[HEIGHT_W-1:0]);
            stalls_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2)) begin
                n = w * h;
                // now and then a frame cut short
                if ($urandom_range(0, 9) == 0) n = int'($urandom_range(1, n));
                if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
                send_pixels(n, int'($urandom_range(0, 255)));
                sent += n;
            end
        end
        stalls_on = 1'b1;
    endtask

    initial begin : run_tests
        int waited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_geometry();
        test_field_extremes();
        test_tiny_frames();
        test_unused_index();
        test_midframe_divisor();
        test_geometry_restart();
        test_tall_frame();
        test_max_width();
        test_random_frames();
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_px.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_px.size() != 0)
            report_mismatch("results never delivered", longint'(expected_px.size()), 64'd0);
        $display("run covered %0d pixel transfers, %0d result transfers, %0d register writes",
                 pixels_sent, results_seen, reg_writes);
        $display("frames from 1x1 up to %0d columns, divisor and output values at both ends",
                 LINE_DEPTH);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/qlcm_pkg.sv
sv/qlcm_div.sv
sv/qlcm_line_buf.sv
sv/quantized_level_contour_map.sv
sv/qlcm_checker.sv
sim/quantized_level_contour_map_tb.sv
